// ===== rtl/fuzzy_number_elementwise_alu_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef FUZZY_NUMBER_ELEMENTWISE_ALU_MACROS_SVH
`define FUZZY_NUMBER_ELEMENTWISE_ALU_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define FNEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, also checked during reset.
`define FNEA_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/fnea_pkg.sv =====
// ----------------------------------------------------------------------------
// fnea_pkg
// Types and constants of the fuzzy number element-wise ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnea_pkg;

    localparam int unsigned QW    = 32;           // Q16.16 word width
    localparam int unsigned QFRAC = 16;           // fraction bits
    localparam int unsigned DVW   = QW + QFRAC;   // dividend and quotient width
    localparam int unsigned OPW   = 3;

    localparam logic [QW-1:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] QMIN = 32'h8000_0000;
    // 1.0 squared in raw units: dividend of the reciprocal
    localparam logic [DVW-1:0] RECIP_ONE = 48'h0001_0000_0000;

    typedef enum logic [OPW-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_QUOT = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // Sideband that travels next to the divider
    typedef struct packed {
        logic [OPW-1:0] op;
        logic           neg_a;
        logic [QW-1:0]  mag_a;
        logic           neg_b;
        logic           zero_b;
        logic [QW-1:0]  mag_b;
        logic [QW-1:0]  as_res;   // add/sub result, already saturated
        logic           as_sat;
        logic           last;
    } t_side;

endpackage

// ===== rtl/fnea_div_step.sv =====
// ----------------------------------------------------------------------------
// fnea_div_step
// One registered restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnea_div_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_vld,
    input  logic [fnea_pkg::QW-1:0]    i_rem,
    input  logic [fnea_pkg::DVW-1:0]   i_sh,
    input  fnea_pkg::t_side            i_side,
    output logic                       o_vld,
    output logic [fnea_pkg::QW-1:0]    o_rem,
    output logic [fnea_pkg::DVW-1:0]   o_sh,
    output fnea_pkg::t_side            o_side
);

    logic                         r_vld;
    logic [fnea_pkg::QW-1:0]      r_rem;
    logic [fnea_pkg::DVW-1:0]     r_sh;
    fnea_pkg::t_side              r_side;
    logic [fnea_pkg::QW:0]        trial;
    logic [fnea_pkg::QW:0]        diff;
    logic                         take;
    logic [fnea_pkg::QW-1:0]      n_rem;
    logic [fnea_pkg::DVW-1:0]     n_sh;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {i_rem, i_sh[fnea_pkg::DVW-1]};
        diff  = trial - {1'b0, i_side.mag_b};
        take  = trial >= {1'b0, i_side.mag_b};
        n_rem = take ? diff[fnea_pkg::QW-1:0] : trial[fnea_pkg::QW-1:0];
        n_sh  = {i_sh[fnea_pkg::DVW-2:0], take};
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_sh   <= n_sh;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_sh   = r_sh;
    assign o_side = r_side;

endmodule

// ===== rtl/fnea_divider.sv =====
// ----------------------------------------------------------------------------
// fnea_divider
// Pipelined unsigned divider, one step per stage, sideband carried along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnea_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_vld,
    input  logic [fnea_pkg::DVW-1:0]   i_dividend,
    input  fnea_pkg::t_side            i_side,
    output logic                       o_vld,
    output logic [fnea_pkg::DVW-1:0]   o_quot,
    output fnea_pkg::t_side            o_side
);

    logic                       vld  [fnea_pkg::DVW+1];
    logic [fnea_pkg::QW-1:0]    rem  [fnea_pkg::DVW+1];
    logic [fnea_pkg::DVW-1:0]   sh   [fnea_pkg::DVW+1];
    fnea_pkg::t_side            side [fnea_pkg::DVW+1];

    assign vld[0]  = i_vld;
    assign rem[0]  = '0;
    assign sh[0]   = i_dividend;
    assign side[0] = i_side;

    // Chain of division steps
    for (genvar g = 0; g < fnea_pkg::DVW; g++) begin : g_step
        fnea_div_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (i_adv),
            .i_vld  (vld[g]),
            .i_rem  (rem[g]),
            .i_sh   (sh[g]),
            .i_side (side[g]),
            .o_vld  (vld[g+1]),
            .o_rem  (rem[g+1]),
            .o_sh   (sh[g+1]),
            .o_side (side[g+1])
        );
    end

    assign o_vld  = vld[fnea_pkg::DVW];
    assign o_quot = sh[fnea_pkg::DVW];
    assign o_side = side[fnea_pkg::DVW];

endmodule

// ===== rtl/fuzzy_number_elementwise_alu.sv =====
// ----------------------------------------------------------------------------
// fuzzy_number_elementwise_alu
// Element-wise add, subtract, multiply, quotient and division on Q16.16.
// ----------------------------------------------------------------------------
// channel   dir  tdata                      tuser          tlast
// s_axis    in   left_value, right_value    req_type       last_in
// m_axis    out  result_value               status         last_out
//
// One word enters per cycle while the pipeline does not hold; each word passes 52
// register stages: one setup stage, 48 divider stages (one quotient bit each), one
// reciprocal stage, one multiplier stage and one packing stage (the output register).
// The whole pipeline holds while the output register is full and not taken.
// Reset is synchronous and clears the valid bits only.
`timescale 1ns / 1ps

module fuzzy_number_elementwise_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] left_value, [63:32] right_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    localparam int unsigned QW  = fnea_pkg::QW;
    localparam int unsigned DVW = fnea_pkg::DVW;

    logic adv;

    // Setup stage
    logic                r_s0_vld;
    logic [DVW-1:0]      r_s0_dvd;
    fnea_pkg::t_side     r_s0_side;
    fnea_pkg::t_side     n_s0_side;
    logic [DVW-1:0]      n_s0_dvd;
    logic signed [QW-1:0] a_s, b_s;
    logic signed [QW:0]   sum;

    // Divider output
    logic                d_vld;
    logic [DVW-1:0]      d_quot;
    fnea_pkg::t_side     d_side;

    // Reciprocal stage
    logic                r_s1_vld;
    fnea_pkg::t_side     r_s1_side;
    logic [QW-1:0]       r_s1_x;
    logic                r_s1_rsat;
    logic [QW-1:0]       r_s1_qres;
    logic                r_s1_qsat;
    logic [QW-1:0]       n_s1_x;
    logic                n_s1_rsat;
    logic [QW-1:0]       n_s1_qres;
    logic                n_s1_qsat;
    logic                qneg;

    // Multiplier stage
    logic                r_s2_vld;
    fnea_pkg::t_side     r_s2_side;
    logic                r_s2_rsat;
    logic [QW-1:0]       r_s2_qres;
    logic                r_s2_qsat;
    logic [2*QW-1:0]     r_s2_prod;

    // Output register
    logic                r_out_vld;
    logic [QW-1:0]       r_out_res;
    logic [1:0]          r_out_st;
    logic                r_out_last;
    logic [QW-1:0]       n_out_res;
    logic [1:0]          n_out_st;
    logic [DVW-1:0]      pm;
    logic                pneg;
    logic                psat;
    logic [QW-1:0]       pres;

    // Move every stage when the output register can take a word
    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;

    // Decode operands and form add/sub result and dividend
    always_comb begin
        a_s = s_axis_tdata[QW-1:0];
        b_s = s_axis_tdata[2*QW-1:QW];
        n_s0_side.op     = s_axis_tuser;
        n_s0_side.neg_a  = a_s[QW-1];
        n_s0_side.mag_a  = a_s[QW-1] ? (~a_s + 1'b1) : a_s;
        n_s0_side.neg_b  = b_s[QW-1];
        n_s0_side.zero_b = (b_s == '0);
        n_s0_side.mag_b  = b_s[QW-1] ? (~b_s + 1'b1) : b_s;
        n_s0_side.last   = s_axis_tlast;
        if (s_axis_tuser == fnea_pkg::OP_SUB) begin
            sum = {a_s[QW-1], a_s} - {b_s[QW-1], b_s};
        end else begin
            sum = {a_s[QW-1], a_s} + {b_s[QW-1], b_s};
        end
        n_s0_side.as_sat = (sum[QW] != sum[QW-1]);
        if (sum[QW] != sum[QW-1]) begin
            n_s0_side.as_res = sum[QW] ? fnea_pkg::QMIN : fnea_pkg::QMAX;
        end else begin
            n_s0_side.as_res = sum[QW-1:0];
        end
        if (s_axis_tuser == fnea_pkg::OP_QUOT) begin
            n_s0_dvd = fnea_pkg::RECIP_ONE;
        end else begin
            n_s0_dvd = {n_s0_side.mag_a, {fnea_pkg::QFRAC{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (adv) begin
            r_s0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_dvd  <= n_s0_dvd;
            r_s0_side <= n_s0_side;
        end
    end

    fnea_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_vld     (r_s0_vld),
        .i_dividend(r_s0_dvd),
        .i_side    (r_s0_side),
        .o_vld     (d_vld),
        .o_quot    (d_quot),
        .o_side    (d_side)
    );

    // Saturate the reciprocal and the direct quotient, pick the multiplicand
    always_comb begin
        if (d_side.neg_b) begin
            n_s1_rsat = d_quot > {{(DVW-QW){1'b0}}, fnea_pkg::QMIN};
        end else begin
            n_s1_rsat = d_quot > {{(DVW-QW){1'b0}}, fnea_pkg::QMAX};
        end
        if (d_side.op == fnea_pkg::OP_MUL) begin
            n_s1_x = d_side.mag_b;
        end else if (n_s1_rsat) begin
            n_s1_x = d_side.neg_b ? fnea_pkg::QMIN : fnea_pkg::QMAX;
        end else begin
            n_s1_x = d_quot[QW-1:0];
        end
        qneg = d_side.neg_a ^ d_side.neg_b;
        if (qneg) begin
            n_s1_qsat = d_quot > {{(DVW-QW){1'b0}}, fnea_pkg::QMIN};
            n_s1_qres = n_s1_qsat ? fnea_pkg::QMIN : (~d_quot[QW-1:0] + 1'b1);
        end else begin
            n_s1_qsat = d_quot > {{(DVW-QW){1'b0}}, fnea_pkg::QMAX};
            n_s1_qres = n_s1_qsat ? fnea_pkg::QMAX : d_quot[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= d_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_side <= d_side;
            r_s1_x    <= n_s1_x;
            r_s1_rsat <= n_s1_rsat;
            r_s1_qres <= n_s1_qres;
            r_s1_qsat <= n_s1_qsat;
            r_s2_side <= r_s1_side;
            r_s2_rsat <= r_s1_rsat;
            r_s2_qres <= r_s1_qres;
            r_s2_qsat <= r_s1_qsat;
            r_s2_prod <= r_s1_side.mag_a * r_s1_x;
        end
    end

    // Pack the product and select the result of the operation
    always_comb begin
        pm   = r_s2_prod[2*QW-1:fnea_pkg::QFRAC];
        pneg = r_s2_side.neg_a ^ r_s2_side.neg_b;
        if (pneg) begin
            psat = pm > {{(DVW-QW){1'b0}}, fnea_pkg::QMIN};
            pres = psat ? fnea_pkg::QMIN : (~pm[QW-1:0] + 1'b1);
        end else begin
            psat = pm > {{(DVW-QW){1'b0}}, fnea_pkg::QMAX};
            pres = psat ? fnea_pkg::QMAX : pm[QW-1:0];
        end
        n_out_res = '0;
        n_out_st  = fnea_pkg::ST_OK;
        case (r_s2_side.op)
            fnea_pkg::OP_ADD, fnea_pkg::OP_SUB: begin
                n_out_res = r_s2_side.as_res;
                n_out_st  = r_s2_side.as_sat ? fnea_pkg::ST_SAT : fnea_pkg::ST_OK;
            end
            fnea_pkg::OP_MUL: begin
                n_out_res = pres;
                n_out_st  = psat ? fnea_pkg::ST_SAT : fnea_pkg::ST_OK;
            end
            fnea_pkg::OP_QUOT: begin
                n_out_res = pres;
                n_out_st  = (psat || r_s2_rsat) ? fnea_pkg::ST_SAT : fnea_pkg::ST_OK;
            end
            fnea_pkg::OP_DIV: begin
                n_out_res = r_s2_qres;
                n_out_st  = r_s2_qsat ? fnea_pkg::ST_SAT : fnea_pkg::ST_OK;
            end
            default: begin
                n_out_res = '0;
                n_out_st  = fnea_pkg::ST_OK;
            end
        endcase
        // Zero divisor overrides both division kinds
        if ((r_s2_side.op == fnea_pkg::OP_QUOT || r_s2_side.op == fnea_pkg::OP_DIV)
            && r_s2_side.zero_b) begin
            n_out_res = r_s2_side.neg_a ? fnea_pkg::QMIN : fnea_pkg::QMAX;
            n_out_st  = fnea_pkg::ST_DIV0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res  <= n_out_res;
            r_out_st   <= n_out_st;
            r_out_last <= r_s2_side.last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_res;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/fnea_checker.sv =====
// ----------------------------------------------------------------------------
// fnea_checker
// Port-level checks of the fuzzy number element-wise ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fuzzy_number_elementwise_alu_macros.svh"

module fnea_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic out_stall;
    logic out_rail;
    logic out_div0;
    logic out_known;

    // Flags of the output word
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_rail  = (m_axis_tdata == fnea_pkg::QMAX) || (m_axis_tdata == fnea_pkg::QMIN);
    assign out_div0  = m_axis_tvalid && (m_axis_tuser == fnea_pkg::ST_DIV0);
    assign out_known = (m_axis_tuser == fnea_pkg::ST_OK) || (m_axis_tuser == fnea_pkg::ST_SAT)
                       || (m_axis_tuser == fnea_pkg::ST_DIV0);

    // A held output word blocks the input side
    `FNEA_ASSERT_IMPL(a_stall_blocks_in, i_clk, i_rst_n, out_stall, !s_axis_tready)
    // Zero divisor always yields a rail value
    `FNEA_ASSERT_IMPL(a_div0_rail, i_clk, i_rst_n, out_div0, out_rail)
    // Status is one of the defined codes
    `FNEA_ASSERT_IMPL(a_status_known, i_clk, i_rst_n, m_axis_tvalid, out_known)
    // Reset empties the output register
    `FNEA_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind fuzzy_number_elementwise_alu fnea_checker u_fnea_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

// ===== tb/sv/fnea_result_checker.sv =====
// ----------------------------------------------------------------------------
// fnea_result_checker
// Watches both streams of the element-wise ALU, predicts each result word
// from the accepted input word and compares status, value and last mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnea_result_checker
    import fnea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic [2:0]  i_in_user,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic [1:0]  i_out_user,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
        logic        last;
    } t_elem_result;

    t_elem_result pending_results[$];

    // Pack a sign and magnitude into a saturated Q16.16 word
    function automatic logic [31:0] saturate_word(input bit neg, input logic [63:0] mag,
                                                  inout bit sat);
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                sat = 1'b1;
                return QMIN;
            end
            return 32'(0 - mag);
        end
        if (mag > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return QMAX;
        end
        return mag[31:0];
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] fixed_product(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  inout bit sat);
        logic [63:0] m;
        m = (magnitude(a) * magnitude(b)) >> QFRAC;
        return saturate_word((a < 0) != (b < 0), m, sat);
    endfunction

    function automatic t_elem_result compute_element(input logic [2:0] op,
                                                     input logic [31:0] lw,
                                                     input logic [31:0] rw,
                                                     input logic last);
        t_elem_result r;
        logic signed [63:0] a, b, s;
        logic [63:0] q;
        logic [31:0] recip;
        bit sat;
        a = 64'(signed'(lw));
        b = 64'(signed'(rw));
        sat = 1'b0;
        r.value = '0;
        r.status = ST_OK;
        r.last = last;
        case (op)
            OP_ADD: begin
                s = a + b;
                r.value = saturate_word(s < 0, magnitude(s), sat);
            end
            OP_SUB: begin
                s = a - b;
                r.value = saturate_word(s < 0, magnitude(s), sat);
            end
            OP_MUL: r.value = fixed_product(a, b, sat);
            OP_QUOT, OP_DIV: begin
                if (b == 0) begin
                    r.value = a < 0 ? QMIN : QMAX;
                    r.status = ST_DIV0;
                end else if (op == OP_QUOT) begin
                    q = (64'd1 << 32) / magnitude(b);
                    recip = saturate_word(b < 0, q, sat);
                    r.value = fixed_product(a, 64'(signed'(recip)), sat);
                end else begin
                    q = (magnitude(a) << QFRAC) / magnitude(b);
                    r.value = saturate_word((a < 0) != (b < 0), q, sat);
                end
            end
            default: r.value = '0;
        endcase
        if (r.status == ST_OK && sat) r.status = ST_SAT;
        return r;
    endfunction

    assign o_pending = pending_results.size();

    // Predict on input words, compare on output words
    always @(posedge i_clk) begin
        t_elem_result exp_r;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                pending_results.insert(pending_results.size(),
                                       compute_element(i_in_user, i_in_data[31:0],
                                                       i_in_data[63:32], i_in_last));
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output word %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.value !== i_out_data || exp_r.status !== i_out_user ||
                        exp_r.last !== i_out_last) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                     exp_r.value, exp_r.status, exp_r.last,
                                     i_out_data, i_out_user, i_out_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_fuzzy_number_elementwise_alu.sv =====
// ----------------------------------------------------------------------------
// tb_fuzzy_number_elementwise_alu
// Drives directed corner words and random operand pairs into the ALU with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fuzzy_number_elementwise_alu;
    import fnea_pkg::*;

    localparam int NUM_RANDOM  = 930;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // [31:0] left_value, [63:32] right_value
    logic [2:0]  s_axis_tuser = '0;   // [2:0] req_type
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] result_value
    logic [1:0]  m_axis_tuser;        // [1:0] status
    logic        m_axis_tlast;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    bit          calm_phase = 1'b0;

    always #4 i_clk = ~i_clk;

    fuzzy_number_elementwise_alu i_dut (.*);

    fnea_result_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser), .i_in_last(s_axis_tlast),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser), .i_out_last(m_axis_tlast),
        .o_fail_count(fail_count), .o_pending(pending_count)
    );

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stall the output in random bursts
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm_phase && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Present one word and hold it until accepted
    task automatic send_word(input logic [2:0] op, input logic [31:0] lw,
                             input logic [31:0] rw, input logic last);
        int n;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rw, lw};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 3) << 16) ^ 32'($urandom_range(0, 255));
            1: return 32'(-($urandom_range(1, 'h3FFFF)));
            2: return 32'($urandom_range(0, 'hFFFFF));
            3: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                      ^ 32'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [31:0] corners[6] = '{32'h0, 32'h1, 32'h0001_0000, 32'hFFFF_FFFF,
                                    32'h7FFF_FFFF, 32'h8000_0000};
        logic [2:0] op;
        logic [31:0] rw;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every operation over corner operands, zero divisors, unused codes
        for (int k = 0; k < 5; k++) begin
            send_word(3'(k), corners[4], corners[4], 1'b0);
            send_word(3'(k), corners[5], corners[$urandom_range(2, 5)], 1'b1);
            send_word(3'(k), corners[$urandom_range(0, 5)], corners[1], 1'b0);
        end
        send_word(OP_QUOT, 32'h0003_0000, 32'h0, 1'b1);
        send_word(OP_DIV, 32'hFFFD_0000, 32'h0, 1'b0);
        send_word(OP_DIV, 32'h0, 32'h0, 1'b1);
        send_word(3'd5, 32'h1234_5678, 32'h1, 1'b1);
        send_word(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

        // Hold off until the pipeline drains
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);

        // Random operand pairs, mostly valid operations
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM - 150) calm_phase = 1'b1;
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            rw = ($urandom_range(0, 24) == 0) ? 32'h0 : random_operand();
            send_word(op, random_operand(), rw, 1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;

        // Drain and settle
        while (pending_count != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
